// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions. Each one expects signals
// named clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define LSH_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Checks the consequent in the cycle after the antecedent.
`define LSH_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// File: sv/lsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laplacian sharpen package
// Sizes, register codes and the beat and job types shared by the filter.
// ----------------------------------------------------------------------------
package lsh_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int PIX_W      = 8;
	localparam int WREG_W     = 12;
	localparam int HREG_W     = 13;
	localparam int CFG_W      = 13;
	localparam int MIN_SIZE   = 3;

	localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(640);
	localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(480);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} lsh_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             start_of_frame;
	} lsh_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             last_of_run;
		logic             end_of_frame;
	} lsh_out_t;

	// Effective frame size, already clamped, held as last index.
	typedef struct packed {
		logic [COL_W-1:0] wm1;
		logic [ROW_W-1:0] hm1;
	} lsh_cfg_t;

	// One classified pixel waiting for the output side.
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] orow;
		logic [COL_W-1:0] col;
		logic             pair;
		logic             last_col;
	} lsh_job_t;

endpackage

// File: sv/lsh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laplacian sharpen front end
// Tracks the raster position, keeps both line stores and works out the
// kernel value for each accepted pixel.
// ----------------------------------------------------------------------------
module lsh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  lsh_pkg::lsh_cfg_t cfg,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  lsh_pkg::lsh_in_t  pix_data,
	output logic              job_push,
	input  logic              job_full,
	output lsh_pkg::lsh_job_t job
);
	import lsh_pkg::*;

	localparam logic [ROW_W-1:0] ROW_ONE = ROW_W'(1);
	localparam logic [COL_W-1:0] COL_ONE = COL_W'(1);

	// Each entry holds {row r-2, row r-1} for one column.
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [PIX_W-1:0]   left_q;

	logic               s1_valid;
	logic [PIX_W-1:0]   pix_s1;
	logic [ROW_W-1:0]   row_s1;
	logic [COL_W-1:0]   col_s1;
	logic               last_col_s1;
	logic               last_row_s1;
	logic [2*PIX_W-1:0] rd_s1;
	logic [PIX_W-1:0]   right_s1;

	logic               accept;
	logic               s1_adv;
	logic               top_row;
	logic [ROW_W-1:0]   r_raw;
	logic [ROW_W-1:0]   r_pos;
	logic [COL_W-1:0]   c_raw;
	logic [COL_W-1:0]   c_pos;
	logic [COL_W-1:0]   c_next;
	logic               at_last_col;
	logic               at_last_row;

	logic               wr_en;
	logic [COL_W-1:0]   wr_addr;
	logic [2*PIX_W-1:0] wr_data;

	logic [PIX_W-1:0]   center;
	logic [PIX_W-1:0]   up;
	logic [PIX_W-1:0]   right;
	logic [PIX_W+2:0]   pos_sum;
	logic [PIX_W+1:0]   neg_sum;
	logic signed [PIX_W+3:0] kern;
	logic [PIX_W-1:0]   sat;
	logic               interior;

	// Position of the incoming pixel, folded into the current frame size.
	always_comb begin
		r_raw       = pix_data.start_of_frame ? '0 : row_q;
		c_raw       = pix_data.start_of_frame ? '0 : col_q;
		r_pos       = (r_raw > cfg.hm1) ? cfg.hm1 : r_raw;
		c_pos       = (c_raw > cfg.wm1) ? cfg.wm1 : c_raw;
		at_last_col = (c_pos == cfg.wm1);
		at_last_row = (r_pos == cfg.hm1);
		c_next      = c_pos + COL_ONE;
	end

	assign top_row   = (row_s1 == '0);
	assign accept    = pix_valid && pix_ready;
	assign s1_adv    = s1_valid && (top_row || !job_full);
	assign pix_ready = !s1_valid || s1_adv;
	assign job_push  = s1_valid && !top_row && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			left_q   <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (accept) begin
				if (at_last_col) begin
					col_q <= '0;
					row_q <= at_last_row ? '0 : r_pos + ROW_ONE;
				end else begin
					col_q <= c_next;
					row_q <= r_pos;
				end
			end
			if (s1_adv) begin
				left_q <= center;
			end
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
		end
	end

	// The stage item writes its column back every cycle it is held; the
	// value does not change, and a read of the same column is forwarded.
	assign wr_en   = s1_valid;
	assign wr_addr = col_s1;
	assign wr_data = {center, pix_s1};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pix_data.pixel_in;
			row_s1      <= r_pos;
			col_s1      <= c_pos;
			last_col_s1 <= at_last_col;
			last_row_s1 <= at_last_row;
			rd_s1       <= (wr_en && wr_addr == c_pos) ? wr_data : line_mem[c_pos];
			right_s1    <= (wr_en && wr_addr == c_next) ? pix_s1
			               : line_mem[c_next][PIX_W-1:0];
		end
	end

	// 5*centre less the four direct neighbours, then clipped to a byte.
	always_comb begin
		center   = rd_s1[PIX_W-1:0];
		up       = rd_s1[2*PIX_W-1:PIX_W];
		right    = last_col_s1 ? '0 : right_s1;
		pos_sum  = {1'b0, center, 2'b00} + {3'b000, center};
		neg_sum  = {2'b00, left_q} + {2'b00, right} + {2'b00, up} + {2'b00, pix_s1};
		kern     = $signed({1'b0, pos_sum}) - $signed({2'b00, neg_sum});
		if (kern[PIX_W+3]) begin
			sat = '0;
		end else if (|kern[PIX_W+2:PIX_W]) begin
			sat = '1;
		end else begin
			sat = kern[PIX_W-1:0];
		end
		interior = (row_s1 != ROW_ONE) && (col_s1 != '0) && !last_col_s1;
	end

	always_comb begin
		job.pix      = interior ? sat : '0;
		job.orow     = row_s1 - ROW_ONE;
		job.col      = col_s1;
		job.pair     = last_row_s1;
		job.last_col = last_col_s1;
	end

endmodule

// File: sv/lsh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laplacian sharpen job queue
// Small first-in first-out store between the front end and the output side.
// ----------------------------------------------------------------------------
module lsh_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lsh_pkg::lsh_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              nonempty,
	output lsh_pkg::lsh_job_t head
);
	import lsh_pkg::*;

	lsh_job_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full     = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: sv/lsh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laplacian sharpen output side
// Turns queued jobs into result beats, two beats for a last-row pixel.
// ----------------------------------------------------------------------------
module lsh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  lsh_pkg::lsh_job_t job,
	output logic              job_pop,
	output logic              res_valid,
	input  logic              res_ready,
	output lsh_pkg::lsh_out_t res_data
);
	import lsh_pkg::*;

	logic     res_valid_q;
	logic     phase_q;
	lsh_out_t res_q;
	lsh_out_t first_beat;
	lsh_out_t second_beat;
	logic     load;

	assign load      = !res_valid_q || res_ready;
	assign job_pop   = load && job_valid && (!job.pair || phase_q);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_comb begin
		first_beat.pixel_out     = job.pix;
		first_beat.out_row       = job.orow;
		first_beat.out_col       = job.col;
		first_beat.last_of_run   = !job.pair;
		first_beat.end_of_frame  = 1'b0;
		second_beat.pixel_out    = '0;
		second_beat.out_row      = job.orow + ROW_W'(1);
		second_beat.out_col      = job.col;
		second_beat.last_of_run  = 1'b1;
		second_beat.end_of_frame = job.last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			res_valid_q <= job_valid;
			if (job_valid) begin
				phase_q <= job.pair && !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && job_valid) begin
			res_q <= phase_q ? second_beat : first_beat;
		end
	end

endmodule

// File: sv/laplacian_sharpen_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laplacian sharpen core
// Five-point Laplacian sharpening of an 8-bit grayscale raster stream.
// ----------------------------------------------------------------------------
// The core takes one pixel beat per clock while the output is not stalled
// and, once the first row of a frame is in, returns the sharpened pixel one
// row above at the same column (5*centre minus the four direct neighbours,
// clipped to 0..255, zero on the frame border); pixels of the last row
// return a second beat, the zero bottom-row pixel. The position counters
// and the 2048-entry line memory are read as a beat enters, the kernel is
// worked out in the next stage, then the beat passes a four-deep queue into
// the output register. The sustained rate is one pixel per clock, set by the
// line memory being read and written back for each pixel; in the last row
// the output side sends two beats per pixel, and the queue and input stage
// absorb that until they fill. The line memory needs no clearing after
// reset: the first row of a frame only fills it. Width and height are
// written over the plain configuration port (index 0 width, index 1 height)
// and are clamped to 3..2048 and 3..4096; change them only between frames
// with the core drained.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  lsh_pkg::lsh_in_t            pix_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output lsh_pkg::lsh_out_t           res_data,
	input  logic                        cfg_en,
	input  logic                        cfg_index,
	input  logic [lsh_pkg::CFG_W-1:0]   cfg_data
);
	import lsh_pkg::*;

	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;
	logic [WREG_W-1:0] width_nx;
	logic [HREG_W-1:0] height_nx;
	lsh_cfg_t          cfg_q;
	lsh_cfg_t          cfg_clamped;

	logic              job_push;
	logic              job_full;
	logic              job_pop;
	logic              job_nonempty;
	lsh_job_t          job_in;
	lsh_job_t          job_head;

	// Register writes. Only two registers exist, so every index names one.
	always_comb begin
		width_nx  = width_q;
		height_nx = height_q;
		if (cfg_en) begin
			case (lsh_reg_t'(cfg_index))
				REG_WIDTH:  width_nx  = cfg_data[WREG_W-1:0];
				REG_HEIGHT: height_nx = cfg_data[HREG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else begin
			width_q  <= width_nx;
			height_q <= height_nx;
		end
	end

	// The frame size is clamped as it is written and held as last indexes,
	// so a beat right after a write already sees the new size, and the
	// position logic downstream sees only a compare against a register.
	always_comb begin
		if (int'(width_nx) < MIN_SIZE) begin
			cfg_clamped.wm1 = COL_W'(MIN_SIZE - 1);
		end else if (int'(width_nx) > MAX_WIDTH) begin
			cfg_clamped.wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			cfg_clamped.wm1 = COL_W'(int'(width_nx) - 1);
		end
		if (int'(height_nx) < MIN_SIZE) begin
			cfg_clamped.hm1 = ROW_W'(MIN_SIZE - 1);
		end else if (int'(height_nx) > MAX_HEIGHT) begin
			cfg_clamped.hm1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			cfg_clamped.hm1 = ROW_W'(int'(height_nx) - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wm1 <= COL_W'(int'(WIDTH_RESET) - 1);
			cfg_q.hm1 <= ROW_W'(int'(HEIGHT_RESET) - 1);
		end else begin
			cfg_q <= cfg_clamped;
		end
	end

	// Front end: position, line memory and kernel.
	lsh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.job_push  (job_push),
		.job_full  (job_full),
		.job       (job_in)
	);

	// Queue that lets the two sides stall independently.
	lsh_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job_in),
		.full     (job_full),
		.pop      (job_pop),
		.nonempty (job_nonempty),
		.head     (job_head)
	);

	// Output side: one or two beats per job into a registered output.
	lsh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_nonempty),
		.job       (job_head),
		.job_pop   (job_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

// File: sv/lsh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laplacian sharpen port checker
// Watches the result port of the core for ordering and border rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input lsh_pkg::lsh_out_t res_data
);
	import lsh_pkg::*;

	// A stalled result beat must hold.
	`LSH_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))

	// The end of a frame is always the last beat of its pixel.
	`LSH_ASSERT_IMP(a_eof_last, res_valid && res_data.end_of_frame, res_data.last_of_run)

	// Border pixels in the first row and column come out as zero.
	`LSH_ASSERT_IMP(a_border_zero, res_valid && (res_data.out_row == '0 || res_data.out_col == '0), res_data.pixel_out == '0)

	// The first beat of a pair is followed at once by the bottom-row beat.
	`LSH_ASSERT_NXT(a_pair_next, res_valid && res_ready && !res_data.last_of_run, res_valid && res_data.last_of_run && res_data.pixel_out == '0 && res_data.out_row == ROW_W'($past(res_data.out_row) + ROW_W'(1)) && res_data.out_col == $past(res_data.out_col))

endmodule

bind laplacian_sharpen_3x3_core lsh_checker u_lsh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data)
);
